// ===== src/stx_pkg.sv =====
package stx_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned NUM_STEPS = 8;

	// Output steps of one job, in line order
	typedef logic [2:0] step_t;
	localparam step_t STEP_START    = 3'd0;
	localparam step_t STEP_DATA_ESC = 3'd1;
	localparam step_t STEP_DATA     = 3'd2;
	localparam step_t STEP_LO_ESC   = 3'd3;
	localparam step_t STEP_LO       = 3'd4;
	localparam step_t STEP_HI_ESC   = 3'd5;
	localparam step_t STEP_HI       = 3'd6;
	localparam step_t STEP_END      = 3'd7;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_START  = 2'd0;
	localparam reg_idx_t REG_END    = 2'd1;
	localparam reg_idx_t REG_ESCAPE = 2'd2;

	localparam logic [7:0] START_RESET  = 8'h02;
	localparam logic [7:0] END_RESET    = 8'h03;
	localparam logic [7:0] ESCAPE_RESET = 8'h10;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] escape_byte;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STEPS-1:0] steps;
		logic [7:0]           data;
		logic [15:0]          sum;
	} job_t;

	function automatic logic is_special(input logic [7:0] b, input cfg_t cfg);
		return (b == cfg.start_byte) || (b == cfg.end_byte) || (b == cfg.escape_byte);
	endfunction

endpackage

// ===== src/stx_front.sv =====
module stx_front (
	input  logic          clk,
	input  logic          arst_n,
	input  stx_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    payload_byte,
	input  logic          frame_first,
	input  logic          frame_last,
	input  logic          q_full,
	output logic          push,
	output stx_pkg::job_t push_job
);
	import stx_pkg::*;

	logic [15:0] sum_q;
	logic        inside_q;
	logic        accept;
	logic [15:0] sum_base;
	logic [15:0] sum_new;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	// drop bytes that arrive outside a frame
	assign push     = accept && (frame_first || inside_q);
	assign sum_base = frame_first ? 16'd0 : sum_q;
	assign sum_new  = sum_base + {8'd0, payload_byte};

	always_comb begin
		push_job.data  = payload_byte;
		push_job.sum   = sum_new;
		push_job.steps = '0;
		push_job.steps[STEP_START]    = frame_first;
		push_job.steps[STEP_DATA_ESC] = is_special(payload_byte, cfg);
		push_job.steps[STEP_DATA]     = 1'b1;
		push_job.steps[STEP_LO_ESC]   = frame_last && is_special(sum_new[7:0], cfg);
		push_job.steps[STEP_LO]       = frame_last;
		push_job.steps[STEP_HI_ESC]   = frame_last && is_special(sum_new[15:8], cfg);
		push_job.steps[STEP_HI]       = frame_last;
		push_job.steps[STEP_END]      = frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			inside_q <= 1'b0;
		end else if (push) begin
			if (frame_last) begin
				sum_q    <= '0;
				inside_q <= 1'b0;
			end else begin
				sum_q    <= sum_new;
				inside_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/stx_queue.sv =====
module stx_queue #(
	parameter int unsigned Depth = stx_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stx_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output stx_pkg::job_t head_job,
	output logic          head_valid
);
	import stx_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== src/stx_back.sv =====
module stx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  stx_pkg::cfg_t cfg,
	input  logic          head_valid,
	input  stx_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    line_byte,
	output logic          run_last,
	output logic          frame_complete
);
	import stx_pkg::*;

	job_t                 cur_q;
	logic [NUM_STEPS-1:0] rem_q;
	logic                 out_valid_q;
	logic [7:0]           line_byte_q;
	logic                 run_last_q;
	logic                 frame_complete_q;

	logic                 emit;
	logic [NUM_STEPS-1:0] low;
	logic [NUM_STEPS-1:0] rem_after;
	step_t                step;
	logic [7:0]           sel_byte;

	assign emit      = (rem_q != '0) && (!out_valid_q || !out_stall);
	assign low       = rem_q & (~rem_q + 1'b1);
	assign rem_after = emit ? (rem_q & ~low) : rem_q;
	// fetch the next job as soon as the current one has nothing left
	assign pop       = (rem_after == '0) && head_valid;

	always_comb begin
		step = STEP_START;
		for (int i = 0; i < NUM_STEPS; i++) begin
			if (low[i]) step = step_t'(i);
		end
	end

	always_comb begin
		unique case (step)
			STEP_START:    sel_byte = cfg.start_byte;
			STEP_DATA_ESC: sel_byte = cfg.escape_byte;
			STEP_DATA:     sel_byte = cur_q.data;
			STEP_LO_ESC:   sel_byte = cfg.escape_byte;
			STEP_LO:       sel_byte = cur_q.sum[7:0];
			STEP_HI_ESC:   sel_byte = cfg.escape_byte;
			STEP_HI:       sel_byte = cur_q.sum[15:8];
			STEP_END:      sel_byte = cfg.end_byte;
			default:       sel_byte = cfg.end_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rem_q <= pop ? head_job.steps : rem_after;
			if (emit)            out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head_job;
		if (emit) begin
			line_byte_q      <= sel_byte;
			run_last_q       <= (rem_after == '0);
			frame_complete_q <= (step == STEP_END);
		end
	end

	assign out_valid      = out_valid_q;
	assign line_byte      = line_byte_q;
	assign run_last       = run_last_q;
	assign frame_complete = frame_complete_q;

endmodule

// ===== src/stx_etx_escaped_frame_builder_unit.sv =====
// Byte-stuffing frame builder: each payload byte accepted on the input channel yields its
// line bytes on the output channel, one transfer per cycle while out_stall is low. A frame's
// first byte is preceded by the start byte, any byte equal to start, end or escape is preceded
// by the escape byte, and the last byte is followed by the 16-bit running sum (low then high,
// each escaped if it equals start, end or escape) and the end byte. An item therefore produces
// 1 to 8 output transfers; the one-byte-per-cycle output register, when not stalled, sets the rate, while input
// bytes are taken every cycle until the job queue between front and back end is full. Bytes
// arriving with no frame open are dropped without output. run_last marks the final transfer
// of each input byte. Configuration writes take effect on the next cycle and must only be
// made while no output is pending.
module stx_etx_escaped_frame_builder_unit #(
	parameter int unsigned QueueDepth = stx_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] payload_byte,
	input  logic       frame_first,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_complete
);
	import stx_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	job_t head_job;
	logic head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= START_RESET;
			cfg_q.end_byte    <= END_RESET;
			cfg_q.escape_byte <= ESCAPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:  cfg_q.start_byte  <= cfg_wdata;
				REG_END:    cfg_q.end_byte    <= cfg_wdata;
				REG_ESCAPE: cfg_q.escape_byte <= cfg_wdata;
				default: ;
			endcase
		end
	end

	stx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.frame_first  (frame_first),
		.frame_last   (frame_last),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	stx_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid)
	);

	stx_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_byte      (line_byte),
		.run_last       (run_last),
		.frame_complete (frame_complete)
	);

endmodule
